>>> rtl/core/ssm_pkg.sv
// Shared types and constants for the stop-string suffix matcher.
// Used by ssm_scan and stop_string_suffix_matcher. No dependencies.
package ssm_pkg;

  // HISTORY_DEPTH, MAX_PATTERNS and MAX_PATTERN_LEN are powers of two:
  // ring and pattern addressing rely on plain wraparound and concatenation.
  localparam int HISTORY_DEPTH   = 256;
  localparam int MAX_PATTERNS    = 8;
  localparam int MAX_PATTERN_LEN = 64;

  localparam int HIST_AW = $clog2(HISTORY_DEPTH);
  localparam int FILL_W  = HIST_AW + 1;
  localparam int PAT_AW  = $clog2(MAX_PATTERNS * MAX_PATTERN_LEN);
  localparam int PSEL_W  = $clog2(MAX_PATTERNS);
  localparam int BSEL_W  = $clog2(MAX_PATTERN_LEN);
  localparam int LEN_W   = 7;
  localparam int CNT_W   = 4;
  localparam int PIDX_W  = 3;
  localparam int BIDX_W  = 6;
  localparam int BYTE_W  = 8;

  typedef enum logic [1:0] {
    OP_TEXT     = 2'd0,
    OP_PAT_BYTE = 2'd1,
    OP_PAT_LEN  = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [PIDX_W-1:0]  pattern_index;
    logic [BIDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0]  byte_value;
    logic [LEN_W-1:0]   pattern_length;
    logic               piece_end;
  } in_t;

  typedef struct packed {
    logic              matched;
    logic [PIDX_W-1:0] match_index;
  } out_t;

  // History state and pattern count seen by the scan sequencer
  typedef struct packed {
    logic [HIST_AW-1:0] head;
    logic [FILL_W-1:0]  fill;
    logic [CNT_W-1:0]   count;
  } ctx_t;

  typedef logic [MAX_PATTERNS-1:0][LEN_W-1:0] len_arr_t;

endpackage

>>> rtl/core/ssm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ssm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/ssm_scan.sv
// Scan sequencer: walks patterns in index order, streams history and pattern
// bytes out of the two RAMs and compares them. Depends on ssm_pkg.
module ssm_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  ssm_pkg::ctx_t             ctx,
  input  ssm_pkg::len_arr_t         lengths,
  output logic [ssm_pkg::HIST_AW-1:0] hist_raddr,
  output logic [ssm_pkg::PAT_AW-1:0]  pat_raddr,
  input  logic [ssm_pkg::BYTE_W-1:0]  hist_rdata,
  input  logic [ssm_pkg::BYTE_W-1:0]  pat_rdata,
  input  logic                      take,
  output logic                      busy,
  output logic                      done,
  output ssm_pkg::out_t             result
);
  import ssm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PAT, S_RUN, S_DONE} state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   p_r;
  logic [LEN_W-1:0]   k_r;
  logic [LEN_W-1:0]   len_r;
  logic [HIST_AW-1:0] base_r;
  logic               cmp_vld_r;
  out_t               result_r;

  logic [CNT_W-1:0]   limit;
  logic [LEN_W-1:0]   cur_len;
  logic               mismatch;

  assign limit    = (ctx.count > CNT_W'(MAX_PATTERNS)) ? CNT_W'(MAX_PATTERNS) : ctx.count;
  assign cur_len  = lengths[p_r[PSEL_W-1:0]];
  assign mismatch = cmp_vld_r && (hist_rdata != pat_rdata);

  assign hist_raddr = base_r + HIST_AW'(k_r);
  assign pat_raddr  = {p_r[PSEL_W-1:0], k_r[BSEL_W-1:0]};

  assign busy   = (state_r != S_IDLE);
  assign done   = (state_r == S_DONE);
  assign result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cmp_vld_r <= 1'b0;
      p_r       <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          cmp_vld_r <= 1'b0;
          if (start) begin
            p_r     <= '0;
            state_r <= S_PAT;
          end
        end
        S_PAT: begin
          cmp_vld_r <= 1'b0;
          if (p_r >= limit) begin
            result_r <= '0;
            state_r  <= S_DONE;
          end else if (cur_len == '0 || FILL_W'(cur_len) > ctx.fill) begin
            p_r <= p_r + 1'b1;
          end else begin
            len_r   <= cur_len;
            base_r  <= ctx.head - HIST_AW'(cur_len);
            k_r     <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (mismatch) begin
            cmp_vld_r <= 1'b0;
            p_r       <= p_r + 1'b1;
            state_r   <= S_PAT;
          end else if (k_r == len_r) begin
            cmp_vld_r            <= 1'b0;
            result_r.matched     <= 1'b1;
            result_r.match_index <= p_r[PIDX_W-1:0];
            state_r              <= S_DONE;
          end else begin
            k_r       <= k_r + 1'b1;
            cmp_vld_r <= 1'b1;
          end
        end
        S_DONE: begin
          cmp_vld_r <= 1'b0;
          if (take) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    done && !result_r.matched |-> result_r.match_index == '0)
    else $error("match_index nonzero without a match");

  a_cmp_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> state_r == S_RUN)
    else $error("compare pending outside a pattern walk");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> k_r <= len_r && len_r != '0)
    else $error("byte counter beyond pattern length");

endmodule

>>> rtl/core/stop_string_suffix_matcher.sv
// Stop-string suffix matcher: text history and pattern store in RAMs, checked at piece ends.
// A piece-end text byte stalls input until its result is registered, which waits on any output
// stall; the RAM walk compares one byte per cycle, and the result passes the output register.
// Synchronous active-low reset clears history, pattern lengths and the count; RAMs keep data.
// Depends on ssm_pkg, ssm_ram, ssm_scan.
module stop_string_suffix_matcher (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ssm_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ssm_pkg::out_t                out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ssm_pkg::CNT_W-1:0]    cfg_data
);
  import ssm_pkg::*;

  logic [HIST_AW-1:0] head_r;
  logic [FILL_W-1:0]  fill_r;
  logic [CNT_W-1:0]   count_r;
  len_arr_t           lengths_r;
  logic               start_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic               acc;
  logic               hist_we;
  logic               pat_we;
  logic [HIST_AW-1:0] hist_raddr;
  logic [PAT_AW-1:0]  pat_raddr;
  logic [BYTE_W-1:0]  hist_rdata;
  logic [BYTE_W-1:0]  pat_rdata;
  logic               scan_busy;
  logic               scan_done;
  logic               take;
  out_t               scan_result;
  ctx_t               ctx;
  logic [LEN_W-1:0]   len_clamped;

  assign in_stall  = start_r || scan_busy;
  assign acc       = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign hist_we   = acc && (in_data.op == OP_TEXT);
  assign pat_we    = acc && (in_data.op == OP_PAT_BYTE)
                     && (32'(in_data.pattern_index) < MAX_PATTERNS)
                     && (32'(in_data.byte_index) < MAX_PATTERN_LEN);
  assign len_clamped = (32'(in_data.pattern_length) > MAX_PATTERN_LEN)
                       ? LEN_W'(MAX_PATTERN_LEN) : in_data.pattern_length;
  assign take      = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ctx.head  = head_r;
  assign ctx.fill  = fill_r;
  assign ctx.count = count_r;

  ssm_ram #(.WIDTH(BYTE_W), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (head_r),
    .wdata (in_data.byte_value),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  ssm_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_PATTERNS * MAX_PATTERN_LEN)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr ({in_data.pattern_index[PSEL_W-1:0], in_data.byte_index[BSEL_W-1:0]}),
    .wdata (in_data.byte_value),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  ssm_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start_r),
    .ctx        (ctx),
    .lengths    (lengths_r),
    .hist_raddr (hist_raddr),
    .pat_raddr  (pat_raddr),
    .hist_rdata (hist_rdata),
    .pat_rdata  (pat_rdata),
    .take       (take),
    .busy       (scan_busy),
    .done       (scan_done),
    .result     (scan_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      count_r     <= '0;
      lengths_r   <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
      if (acc) begin
        unique case (in_data.op)
          OP_TEXT: begin
            head_r <= head_r + 1'b1;
            if (fill_r != FILL_W'(HISTORY_DEPTH)) begin
              fill_r <= fill_r + 1'b1;
            end
            start_r <= in_data.piece_end;
          end
          OP_PAT_BYTE: ;
          OP_PAT_LEN: begin
            if (32'(in_data.pattern_index) < MAX_PATTERNS) begin
              lengths_r[in_data.pattern_index[PSEL_W-1:0]] <= len_clamped;
            end
          end
          OP_CLEAR: begin
            head_r <= '0;
            fill_r <= '0;
          end
          default: ;
        endcase
      end
      if (scan_done && take) begin
        out_valid_r <= 1'b1;
        out_data_r  <= scan_result;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
